FILE: hw/rtl/assert_macros.svh
// Assertion helpers included by the top-level RTL file.
// ASSERT_PROP checks a property at every rising clock edge outside reset.
// ASSERT_NEVER checks that an expression is never true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

FILE: hw/rtl/cnv_pkg.sv
package cnv_pkg;

	// Image and kernel geometry.
	localparam int MAX_DIM    = 32;
	localparam int KDIM       = 5;
	localparam int TAPS       = KDIM * KDIM;
	localparam int PIX_W      = 8;
	localparam int DIM_W      = $clog2(MAX_DIM + 1);
	localparam int COL_W      = $clog2(MAX_DIM);
	localparam int POS_W      = 5;
	localparam int LINE_W     = (KDIM - 1) * PIX_W;
	localparam int POOL_DEPTH = MAX_DIM / 2;
	localparam int PC_W       = $clog2(POOL_DEPTH);

	// Window sum: 32-bit bias plus 25 products of 8-bit operands never wraps in 33 bits.
	localparam int ACC_W = 33;
	localparam int BIAS_W = 32;

	// Configuration port.
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_MID  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LAST  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_DIM    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_ENABLE  = 3'd6;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic [TAPS*PIX_W-1:0] win_t;

	// Output-map position that travels with a window through the chain.
	typedef struct packed {
		logic [POS_W-1:0] orow;
		logic [POS_W-1:0] ocol;
	} tag_t;

endpackage

FILE: hw/rtl/cnv_ram.sv
module cnv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port; read data holds without a read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/cnv_mac_cell.sv
module cnv_mac_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             valid_in,
	input  cnv_pkg::tag_t                    tag_in,
	input  cnv_pkg::acc_t                    psum_in,
	input  cnv_pkg::win_t                    win_in,
	input  logic signed [cnv_pkg::PIX_W-1:0] weight,
	output logic                             valid_q,
	output cnv_pkg::tag_t                    tag_q,
	output cnv_pkg::acc_t                    psum_q,
	output cnv_pkg::win_t                    win_q
);
	import cnv_pkg::*;

	logic signed [2*PIX_W:0] prod;

	// The lowest byte of the window is this cell's tap; the pixel is unsigned.
	assign prod = $signed({1'b0, win_in[PIX_W-1:0]}) * weight;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	// Add this tap and hand the rest of the window to the next cell.
	always_ff @(posedge clk) begin
		if (en) begin
			tag_q  <= tag_in;
			psum_q <= psum_in + ACC_W'(prod);
			win_q  <= win_in >> PIX_W;
		end
	end

endmodule

FILE: hw/rtl/cnv_pool.sv
module cnv_pool (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            valid_in,
	input  cnv_pkg::tag_t                   tag_in,
	input  cnv_pkg::acc_t                   acc_in,
	input  logic                            pool_en,
	input  logic [cnv_pkg::DIM_W-1:0]       od,
	output logic                            out_valid_q,
	output logic [cnv_pkg::PIX_W-1:0]       value_q,
	output logic [cnv_pkg::POS_W-1:0]       out_row_q,
	output logic [cnv_pkg::POS_W-1:0]       out_col_q,
	output logic                            last_q
);
	import cnv_pkg::*;

	pix_t             act;
	logic             valid_s1;
	pix_t             v_s1;
	tag_t             tag_s1;

	pix_t             left_q;
	pix_t             upper_q [POOL_DEPTH];

	logic [DIM_W-1:0] pd;
	logic [DIM_W-1:0] pd2;
	logic [DIM_W-1:0] orow_x;
	logic [DIM_W-1:0] ocol_x;
	logic [PC_W-1:0]  pc;
	logic [POS_W-1:0] pr;
	logic             in_map;
	pix_t             pair;
	pix_t             up;
	logic             emit;
	pix_t             emit_value;
	logic [POS_W-1:0] emit_row;
	logic [POS_W-1:0] emit_col;
	logic             emit_last;

	// ReLU, divide by 256 and saturate.
	always_comb begin
		if (acc_in[ACC_W-1] || (acc_in == '0)) begin
			act = '0;
		end else if (|acc_in[ACC_W-2:2*PIX_W]) begin
			act = '1;
		end else begin
			act = acc_in[2*PIX_W-1:PIX_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1   <= act;
			tag_s1 <= tag_in;
		end
	end

	// Pooling geometry and the pair and block maxima.
	always_comb begin
		pd     = od >> 1;
		pd2    = {od[DIM_W-1:1], 1'b0};
		orow_x = DIM_W'(tag_s1.orow);
		ocol_x = DIM_W'(tag_s1.ocol);
		in_map = (orow_x < pd2) && (ocol_x < pd2);
		pc     = PC_W'(tag_s1.ocol >> 1);
		pr     = tag_s1.orow >> 1;
		pair   = (left_q > v_s1) ? left_q : v_s1;
		up     = upper_q[pc];

		emit       = 1'b0;
		emit_value = v_s1;
		emit_row   = tag_s1.orow;
		emit_col   = tag_s1.ocol;
		emit_last  = (orow_x == od - 1'b1) && (ocol_x == od - 1'b1);
		if (!pool_en) begin
			emit = valid_s1;
		end else begin
			emit       = valid_s1 && in_map && tag_s1.ocol[0] && tag_s1.orow[0];
			emit_value = (up > pair) ? up : pair;
			emit_row   = pr;
			emit_col   = POS_W'(pc);
			emit_last  = (DIM_W'(pr) == pd - 1'b1) && (DIM_W'(pc) == pd - 1'b1);
		end
	end

	// Left value of the current pair and the upper pair maxima per pooled column.
	always_ff @(posedge clk) begin
		if (en && valid_s1 && pool_en && in_map) begin
			if (!tag_s1.ocol[0]) begin
				left_q <= v_s1;
			end else if (!tag_s1.orow[0]) begin
				upper_q[pc] <= pair;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en && emit) begin
			value_q   <= emit_value;
			out_row_q <= emit_row;
			out_col_q <= emit_col;
			last_q    <= emit_last;
		end
	end

endmodule

FILE: hw/rtl/conv5x5_relu_maxpool2x2.sv
// Channel  | Handshake           | Beat contents
// ---------+---------------------+------------------------------------
// pixel in | in_valid, in_stall  | pixel
// result   | out_valid, out_stall| value, out_row, out_col, last
// config   | cfg_we              | cfg_index, cfg_data
//
// One pixel beat is taken every cycle while the result side does not stall.
// A result passes from its pixel beat through the line-store read, window
// register, 25 multiply-add cells, activation, pool and output register.
// A stalled result freezes the whole pipeline and raises in_stall.
// Reset clears counters and valid bits; the line store is not cleared.
`include "assert_macros.svh"

module conv5x5_relu_maxpool2x2 (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [cnv_pkg::PIX_W-1:0]       pixel,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [cnv_pkg::PIX_W-1:0]       value,
	output logic [cnv_pkg::POS_W-1:0]       out_row,
	output logic [cnv_pkg::POS_W-1:0]       out_col,
	output logic                            last,
	input  logic                            cfg_we,
	input  logic [cnv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cnv_pkg::CFG_W-1:0]       cfg_data
);
	import cnv_pkg::*;

	// Configuration registers.
	logic [CFG_W-1:0]  weights_low_q;
	logic [CFG_W-1:0]  weights_mid_q;
	logic [CFG_W-1:0]  weights_high_q;
	logic [PIX_W-1:0]  weight_last_q;
	logic [BIAS_W-1:0] bias_q;
	logic [DIM_W-1:0]  image_dim_q;
	logic              pool_en_q;

	logic [DIM_W-1:0]  dim_eff;
	logic [DIM_W-1:0]  od;
	win_t              weights_all;

	logic              en;
	logic              accept;
	logic [DIM_W-1:0]  in_row_q;
	logic [DIM_W-1:0]  in_col_q;
	logic [DIM_W-1:0]  cur_row;
	logic [DIM_W-1:0]  cur_col;
	logic [DIM_W-1:0]  nxt_row;
	logic [DIM_W-1:0]  nxt_col;

	logic              valid_s1;
	pix_t              pix_s1;
	logic [DIM_W-1:0]  row_s1;
	logic [DIM_W-1:0]  col_s1;

	logic              line_we;
	logic [LINE_W-1:0] line_rdata;
	logic [LINE_W-1:0] line_wdata;

	win_t              win_q;
	win_t              win_nx;
	logic              win_v_s2;
	tag_t              tag_s2;

	logic              valid_c [TAPS+1];
	tag_t              tag_c   [TAPS+1];
	acc_t              psum_c  [TAPS+1];
	win_t              win_c   [TAPS+1];

	// Configuration writes; a new size or mode restarts the image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_low_q  <= '0;
			weights_mid_q  <= '0;
			weights_high_q <= '0;
			weight_last_q  <= '0;
			bias_q         <= '0;
			image_dim_q    <= DIM_W'(MAX_DIM);
			pool_en_q      <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WEIGHTS_LOW:  weights_low_q  <= cfg_data;
				REG_WEIGHTS_MID:  weights_mid_q  <= cfg_data;
				REG_WEIGHTS_HIGH: weights_high_q <= cfg_data;
				REG_WEIGHT_LAST:  weight_last_q  <= cfg_data[PIX_W-1:0];
				REG_BIAS:         bias_q         <= cfg_data[BIAS_W-1:0];
				REG_IMAGE_DIM:    image_dim_q    <= cfg_data[DIM_W-1:0];
				REG_POOL_ENABLE:  pool_en_q      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Image size clamped to the supported range, and the window map size.
	always_comb begin
		if (image_dim_q < DIM_W'(KDIM)) begin
			dim_eff = DIM_W'(KDIM);
		end else if (image_dim_q > DIM_W'(MAX_DIM)) begin
			dim_eff = DIM_W'(MAX_DIM);
		end else begin
			dim_eff = image_dim_q;
		end
		od = dim_eff - DIM_W'(KDIM - 1);
	end

	assign weights_all = {weight_last_q, weights_high_q, weights_mid_q, weights_low_q};

	// The whole pipeline moves unless a finished result is held.
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;
	assign accept   = in_valid && en;

	// Position of the incoming pixel and of the one after it.
	always_comb begin
		if ((in_row_q >= dim_eff) || (in_col_q >= dim_eff)) begin
			cur_row = '0;
			cur_col = '0;
		end else begin
			cur_row = in_row_q;
			cur_col = in_col_q;
		end
		nxt_row = cur_row;
		nxt_col = cur_col + 1'b1;
		if (nxt_col >= dim_eff) begin
			nxt_col = '0;
			nxt_row = cur_row + 1'b1;
			if (nxt_row >= dim_eff) begin
				nxt_row = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q <= '0;
			in_col_q <= '0;
		end else if (cfg_we && ((cfg_index == REG_IMAGE_DIM) ||
				(cfg_index == REG_POOL_ENABLE))) begin
			in_row_q <= '0;
			in_col_q <= '0;
		end else if (accept) begin
			in_row_q <= nxt_row;
			in_col_q <= nxt_col;
		end
	end

	// Stage 1: pixel beside the four older pixels of its column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pixel;
			row_s1 <= cur_row;
			col_s1 <= cur_col;
		end
	end

	// Line store: one word per column holds the four rows above the current one.
	assign line_we    = en && valid_s1;
	assign line_wdata = {line_rdata[LINE_W-PIX_W-1:0], pix_s1};

	cnv_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_DIM)
	) u_line_store (
		.clk   (clk),
		.we    (line_we),
		.waddr (col_s1[COL_W-1:0]),
		.wdata (line_wdata),
		.re    (accept),
		.raddr (cur_col[COL_W-1:0]),
		.rdata (line_rdata)
	);

	// Window shifts left by one column; the new column enters on the right.
	always_comb begin
		for (int kr = 0; kr < KDIM; kr++) begin
			for (int kc = 0; kc < KDIM - 1; kc++) begin
				win_nx[(kr*KDIM+kc)*PIX_W +: PIX_W] = win_q[(kr*KDIM+kc+1)*PIX_W +: PIX_W];
			end
			if (kr < KDIM - 1) begin
				win_nx[(kr*KDIM+KDIM-1)*PIX_W +: PIX_W] =
					line_rdata[(KDIM-2-kr)*PIX_W +: PIX_W];
			end else begin
				win_nx[(kr*KDIM+KDIM-1)*PIX_W +: PIX_W] = pix_s1;
			end
		end
	end

	// Stage 2: the window register; a window is whole once row and column reach 4.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_v_s2 <= 1'b0;
		end else if (en) begin
			win_v_s2 <= valid_s1 && (row_s1 >= DIM_W'(KDIM - 1)) &&
				(col_s1 >= DIM_W'(KDIM - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			win_q       <= win_nx;
			tag_s2.orow <= POS_W'(row_s1 - DIM_W'(KDIM - 1));
			tag_s2.ocol <= POS_W'(col_s1 - DIM_W'(KDIM - 1));
		end
	end

	// Chain of multiply-add cells, one tap each, starting from the bias.
	assign valid_c[0] = win_v_s2;
	assign tag_c[0]   = tag_s2;
	assign psum_c[0]  = ACC_W'($signed(bias_q));
	assign win_c[0]   = win_q;

	for (genvar j = 0; j < TAPS; j++) begin : g_cell
		cnv_mac_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (valid_c[j]),
			.tag_in   (tag_c[j]),
			.psum_in  (psum_c[j]),
			.win_in   (win_c[j]),
			.weight   ($signed(weights_all[j*PIX_W +: PIX_W])),
			.valid_q  (valid_c[j+1]),
			.tag_q    (tag_c[j+1]),
			.psum_q   (psum_c[j+1]),
			.win_q    (win_c[j+1])
		);
	end

	// Activation, pooling and the output register.
	cnv_pool u_pool (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.valid_in    (valid_c[TAPS]),
		.tag_in      (tag_c[TAPS]),
		.acc_in      (psum_c[TAPS]),
		.pool_en     (pool_en_q),
		.od          (od),
		.out_valid_q (out_valid),
		.value_q     (value),
		.out_row_q   (out_row),
		.out_col_q   (out_col),
		.last_q      (last)
	);

	`ASSERT_PROP(a_hold_stalls_input, clk, arst_n, (out_valid && out_stall) |-> in_stall, "input taken while result held")
	`ASSERT_PROP(a_accept_reaches_s1, clk, arst_n, (in_valid && !in_stall) |=> valid_s1, "accepted pixel lost before stage 1")
	`ASSERT_NEVER(a_counter_range, clk, arst_n, (in_row_q >= dim_eff) || (in_col_q >= dim_eff), "pixel counter beyond image size")

endmodule
